[src/wsr_pkg.sv]
// Package for the windowed sinc resampler: constants, types and kernel tables.
`default_nettype none
package wsr_pkg;

  localparam int HALF_TAPS   = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RUN     = 64;
  localparam int WIN_LEN     = 2 * HALF_TAPS;

  localparam int STEP_W   = 20;
  localparam int CUT_W    = 17;
  localparam int SCALE_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int OWED_W   = 5;
  localparam int TAP_W    = $clog2(WIN_LEN);
  localparam int RUN_W    = $clog2(MAX_RUN + 1);
  localparam int POS_W    = $clog2(HALF_TAPS) + FRAC_W + 1;
  localparam int IDX_SH   = $clog2(TABLE_SIZE / HALF_TAPS);
  localparam int IDX_W    = POS_W + IDX_SH;
  localparam int TIDX_W   = $clog2(TABLE_SIZE + 2);
  localparam int TAB_W    = 18;
  localparam int MA_W     = 22;
  localparam int MB_W     = 19;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int NUM_W    = 40;
  localparam int DEN_W    = 23;
  localparam int KSUM_W   = 23;

  localparam logic [STEP_W-1:0]  STEP_RESET = 20'd65536;
  localparam logic [CUT_W-1:0]   CUT_RESET  = 17'd62259;
  localparam logic [SCALE_W-1:0] SCALE_ONE  = 17'd65536;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd62259;
  localparam logic [STEP_W-1:0]  STEP_MIN   = 20'd1024;

  localparam logic [0:0] REG_STEP   = 1'b0;
  localparam logic [0:0] REG_CUTOFF = 1'b1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  typedef logic signed [TAB_W-1:0] tab_t [TABLE_SIZE+2];

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_SA, ST_HW, ST_SI, ST_KW, ST_AC, ST_DIVS, ST_DIVW, ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [63:0] sin_pi_q30(logic [63:0] num_in, logic half);
    logic [63:0] num;
    logic [63:0] theta;
    logic [63:0] mag;
    logic signed [63:0] sum;
    num = num_in;
    if (half) begin
      if (num > 2 * TABLE_SIZE) num = 2 * TABLE_SIZE;
      if (2 * num > 2 * TABLE_SIZE) num = 2 * TABLE_SIZE - num;
      theta = PI_Q30 * num / (2 * TABLE_SIZE);
    end else begin
      if (num > TABLE_SIZE) num = TABLE_SIZE;
      if (2 * num > TABLE_SIZE) num = TABLE_SIZE - num;
      theta = PI_Q30 * num / TABLE_SIZE;
    end
    mag = theta;
    sum = $signed(theta);
    for (int k = 1; k <= 7; k++) begin
      mag = (mag * theta) >> 30;
      mag = (mag * theta) >> 30;
      mag = mag / TAYLOR_DIV[k];
      if (k % 2 == 1) sum = sum - $signed(mag);
      else sum = sum + $signed(mag);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic tab_t build_hann();
    tab_t t;
    logic [63:0] s;
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      s = sin_pi_q30(64'(i), 1'b1);
      t[i] = TAB_W'(64'd65536 - ((s * s + (64'd1 << 43)) >> 44));
    end
    t[TABLE_SIZE+1] = '0;
    return t;
  endfunction

  function automatic tab_t build_sinc();
    tab_t t;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] num;
    logic [63:0] Den;
    logic [63:0] v;
    t[0] = TAB_W'(65536);
    for (int i = 1; i <= TABLE_SIZE; i++) begin
      p   = 64'(i) * HALF_TAPS;
      q   = p / TABLE_SIZE;
      r   = p % TABLE_SIZE;
      num = (sin_pi_q30(r, 1'b0) * TABLE_SIZE) << 16;
      Den = PI_Q30 * p;
      v   = (num + Den / 2) / Den;
      t[i] = q[0] ? -TAB_W'(v) : TAB_W'(v);
    end
    t[TABLE_SIZE+1] = '0;
    return t;
  endfunction

  localparam tab_t HANN_TAB = build_hann();
  localparam tab_t SINC_TAB = build_sinc();

endpackage
`default_nettype wire

[src/wsr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module wsr_div import wsr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule
`default_nettype wire

[src/windowed_sinc_resampler.sv]
// Windowed sinc resampler top level: sample window, tap sequencer, shared multiplier.
// An input that owes further samples is taken and causes no output.
// Each output runs states SA, HW, SI, KW and AC per tap on the shared multiplier,
// then starts the divide unless the kernel sum is zero, waits for it and emits.
// A register write recomputes the kernel scale; the divider is used if step > cutoff.
// Reset clears window, phase and out valid, owes 16 samples, loads the default scale.
`default_nettype none
module windowed_sinc_resampler import wsr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_o,
  output logic                               last_of_run_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  state_e state_q, state_d;

  logic [STEP_W-1:0]  step_q;
  logic [CUT_W-1:0]   cut_q;
  logic [SCALE_W-1:0] scale_q;
  logic               scale_pend_q;
  logic signed [SAMPLE_BITS-1:0] win_q [WIN_LEN];
  logic [FRAC_W-1:0]  phase_q;
  logic [OWED_W-1:0]  owed_q;
  logic [TAP_W-1:0]   tap_q;
  logic [RUN_W-1:0]   run_q;
  logic [POS_W-1:0]   sa_q;
  logic signed [TAB_W-1:0] w_q, s_q, k_q;
  logic signed [NUM_W-1:0]  ssum_q;
  logic signed [KSUM_W-1:0] ksum_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic               out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic               last_q;

  logic               cfg_wr, in_acc, emit_load, emit_last, run_start;
  logic [STEP_W-1:0]  eff_step;
  logic [OWED_W-1:0]  owed_dec;
  logic [STEP_W:0]    acc_sum;
  logic [OWED_W-1:0]  owed_new;
  logic signed [POS_W+1:0] xpos;
  logic [POS_W-1:0]   apos;
  logic [IDX_W-1:0]   idx_u;
  logic [IDX_W-FRAC_W-1:0] idx_hi;
  logic [TIDX_W-1:0]  left;
  logic [FRAC_W-1:0]  frac;
  logic signed [TAB_W-1:0] lv, rv, interp;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic               q_neg;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  localparam logic [NUM_W-1:0] SAT_POS = NUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(1 << (SAMPLE_BITS - 1));

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2:2] == REG_CUTOFF) ? 32'(cut_q) : 32'(step_q);
  assign eff_step = (step_q < STEP_MIN) ? STEP_MIN : step_q;

  assign in_stall_o = (state_q != ST_IDLE) || scale_pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign owed_dec   = (owed_q != '0) ? owed_q - 1'b1 : owed_q;
  assign run_start  = in_acc && (owed_dec == '0);

  assign acc_sum   = {1'b0, eff_step} + (STEP_W + 1)'(phase_q);
  assign owed_new  = acc_sum[STEP_W:FRAC_W];
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign emit_last = (owed_new != '0) || (run_q == RUN_W'(MAX_RUN - 1));

  // tap position relative to the phase, and its magnitude
  assign xpos = $signed({(POS_W+2-FRAC_W)'(tap_q), FRAC_W'(0)})
              - $signed((POS_W+2)'((HALF_TAPS - 1) << FRAC_W))
              - $signed((POS_W+2)'(phase_q));
  assign apos = xpos[POS_W+1] ? POS_W'(-xpos) : POS_W'(xpos);

  always_comb begin
    idx_u  = (state_q == ST_HW) ? {apos, IDX_SH'(0)} : {sa_q, IDX_SH'(0)};
    idx_hi = idx_u[IDX_W-1:FRAC_W];
    if (idx_hi > (IDX_W-FRAC_W)'(TABLE_SIZE)) begin
      left = TIDX_W'(TABLE_SIZE);
      frac = '0;
    end else begin
      left = TIDX_W'(idx_hi);
      frac = idx_u[FRAC_W-1:0];
    end
    if (state_q == ST_HW) begin
      lv = HANN_TAB[left];
      rv = HANN_TAB[left + 1'b1];
    end else begin
      lv = SINC_TAB[left];
      rv = SINC_TAB[left + 1'b1];
    end
  end

  always_comb begin
    case (state_q)
      ST_SA: begin
        mul_a = $signed(MA_W'(apos));
        mul_b = $signed(MB_W'(scale_q));
      end
      ST_HW, ST_SI: begin
        mul_a = MA_W'(rv - lv);
        mul_b = $signed(MB_W'(frac));
      end
      ST_KW: begin
        mul_a = MA_W'(s_q);
        mul_b = MB_W'(w_q);
      end
      ST_AC: begin
        mul_a = MA_W'(k_q);
        mul_b = MB_W'(win_q[tap_q]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign interp = lv + TAB_W'(prod >>> FRAC_W);

  always_comb begin
    q_neg = ssum_q[NUM_W-1] ^ ksum_q[KSUM_W-1];
    if (!q_neg) begin
      y_sat = (div_rsp.quot > SAT_POS) ? SAMPLE_BITS'(SAT_POS) : SAMPLE_BITS'(div_rsp.quot);
    end else begin
      y_sat = (div_rsp.quot > SAT_NEG) ? SAMPLE_BITS'(SAT_NEG) : -SAMPLE_BITS'(div_rsp.quot);
    end
  end

  always_comb begin
    div_req = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (scale_pend_q) begin
          if (eff_step > STEP_W'(cut_q)) begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({cut_q, FRAC_W'(0)});
            div_req.den   = DEN_W'(eff_step);
            state_d       = ST_SCALE;
          end
        end else if (run_start) begin
          state_d = ST_SA;
        end
      end
      ST_SCALE: if (div_rsp.done) state_d = ST_IDLE;
      ST_SA:    state_d = ST_HW;
      ST_HW:    state_d = ST_SI;
      ST_SI:    state_d = ST_KW;
      ST_KW:    state_d = ST_AC;
      ST_AC:    state_d = (tap_q == TAP_W'(WIN_LEN - 1)) ? ST_DIVS : ST_SA;
      ST_DIVS: begin
        if (ksum_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = ssum_q[NUM_W-1] ? NUM_W'(-ssum_q) : NUM_W'(ssum_q);
          div_req.den   = ksum_q[KSUM_W-1] ? DEN_W'(-ksum_q) : DEN_W'(ksum_q);
          state_d       = ST_DIVW;
        end
      end
      ST_DIVW: if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT: if (emit_load) state_d = emit_last ? ST_IDLE : ST_SA;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= STEP_RESET;
      cut_q        <= CUT_RESET;
      scale_q      <= SCALE_RESET;
      scale_pend_q <= 1'b0;
      phase_q      <= '0;
      owed_q       <= OWED_W'(HALF_TAPS);
      run_q        <= '0;
      tap_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2:2] == REG_STEP) step_q <= pwdata[STEP_W-1:0];
        else cut_q <= pwdata[CUT_W-1:0];
        scale_pend_q <= 1'b1;
      end else if (state_q == ST_IDLE && scale_pend_q) begin
        scale_pend_q <= 1'b0;
        if (!(eff_step > STEP_W'(cut_q))) scale_q <= SCALE_ONE;
      end
      if (state_q == ST_SCALE && div_rsp.done) scale_q <= div_rsp.quot[SCALE_W-1:0];
      if (in_acc) begin
        for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] <= win_q[i+1];
        win_q[WIN_LEN-1] <= in_sample_i;
        owed_q <= owed_dec;
        run_q  <= '0;
        tap_q  <= '0;
      end
      if (state_q == ST_AC) tap_q <= tap_q + 1'b1;
      if (emit_load) begin
        phase_q <= acc_sum[FRAC_W-1:0];
        owed_q  <= owed_new;
        run_q   <= run_q + 1'b1;
        tap_q   <= '0;
      end
      if (emit_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SA: sa_q <= prod[POS_W+FRAC_W-1:FRAC_W];
      ST_HW: w_q  <= interp;
      ST_SI: s_q  <= interp;
      ST_KW: k_q  <= TAB_W'(prod >>> FRAC_W);
      ST_AC: begin
        ssum_q <= ssum_q + NUM_W'(prod);
        ksum_q <= ksum_q + KSUM_W'(k_q);
      end
      ST_DIVS: y_q <= '0;
      ST_DIVW: if (div_rsp.done) y_q <= y_sat;
      default: ;
    endcase
    if (run_start || (emit_load && !emit_last)) begin
      ssum_q <= '0;
      ksum_q <= '0;
    end
    if (emit_load) begin
      out_sample_q <= y_q;
      last_q       <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign last_of_run_o = last_q;

  wsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && !emit_last) |=> (state_q == ST_SA && tap_q == '0))
    else $error("run did not restart at first tap");

  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AC && tap_q == TAP_W'(WIN_LEN - 1)) |=> state_q == ST_DIVS)
    else $error("last tap did not lead to divide");

  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_req.start && state_q == ST_DIVS) |-> ksum_q != '0)
    else $error("divide by zero kernel sum");

endmodule
`default_nettype wire
